[design/esd_pkg.sv]
// Shared types and constants for the escape sequence decoder.
// No dependencies; esd_decode, esd_emit, the top level and the checker import it.
`default_nettype none

package esd_pkg;

    // End-of-string status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SYNTAX = 2'd1,
        ST_FORMAT = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    // Up to three results caused by one input word, in delivery order:
    // a gathered hex byte, a plain/escaped byte, then the status.
    typedef struct packed {
        logic       hex_valid;
        logic [7:0] hex_byte;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       status_valid;
        status_t    status;
    } result_set_t;

endpackage

`default_nettype wire

[design/esd_if.sv]
// Valid/ready channel interfaces for the escape sequence decoder.
// Depends on nothing; used by the top level and esd_emit.
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_data;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output is_data, output status,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input is_data, input status,
                    input last, output ready);
endinterface

`default_nettype wire

[design/esd_decode.sv]
// Per-byte decode: escape/hex state registers and the next-state logic.
// Depends on esd_pkg.
`default_nettype none

module esd_decode
    import esd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_string,
    output result_set_t      results
);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2,
        MODE_DROP   = 2'd3
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    mode_t      mode_reg, mode_next;
    logic [7:0] hex_value_reg, hex_value_next;
    logic       hex_seen_reg, hex_seen_next;
    logic       hex_ovf_reg, hex_ovf_next;
    status_t    err_reg, err_next;

    logic       digit_ok;
    logic [3:0] digit_val;
    logic       go_on;
    logic       clear_all;
    mode_t      eff_mode;

    // Hex digit classification
    always_comb
    begin
        digit_ok  = 1'b0;
        digit_val = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            digit_ok = 1'b1;
        end
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
        begin
            digit_ok  = 1'b1;
            digit_val = in_byte[3:0] + 4'd9;
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        hex_value_next = hex_value_reg;
        hex_seen_next  = hex_seen_reg;
        hex_ovf_next   = hex_ovf_reg;
        err_next       = err_reg;
        results        = '0;
        go_on          = 1'b1;
        clear_all      = 1'b0;
        eff_mode       = mode_reg;

        unique case (mode_reg)
            MODE_DROP:
            begin
                go_on = 1'b0;
                if (end_of_string)
                begin
                    results.status_valid = 1'b1;
                    results.status       = err_reg;
                    clear_all            = 1'b1;
                end
            end
            MODE_HEX:
            begin
                if (digit_ok)
                begin
                    go_on          = 1'b0;
                    hex_ovf_next   = hex_ovf_reg | (hex_value_reg[7:4] != 4'd0);
                    hex_value_next = {hex_value_reg[3:0], digit_val};
                    hex_seen_next  = 1'b1;
                    if (end_of_string)
                    begin
                        results.status_valid = 1'b1;
                        results.status       = ST_SYNTAX;
                        clear_all            = 1'b1;
                    end
                end
                else if (!hex_seen_reg || hex_ovf_reg)
                begin
                    go_on = 1'b0;
                    if (end_of_string)
                    begin
                        results.status_valid = 1'b1;
                        results.status       = hex_seen_reg ? ST_RANGE : ST_FORMAT;
                        clear_all            = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_DROP;
                        err_next  = hex_seen_reg ? ST_RANGE : ST_FORMAT;
                    end
                end
                else
                begin
                    // Run ends: emit the gathered byte, then treat this byte normally
                    results.hex_valid = 1'b1;
                    results.hex_byte  = hex_value_reg;
                    eff_mode          = MODE_NORMAL;
                    mode_next         = MODE_NORMAL;
                    hex_value_next    = 8'd0;
                    hex_seen_next     = 1'b0;
                    hex_ovf_next      = 1'b0;
                end
            end
            MODE_ESCAPE: ;
            MODE_NORMAL: ;
        endcase

        if (go_on)
        begin
            if (eff_mode == MODE_ESCAPE)
            begin
                mode_next = MODE_NORMAL;
                priority if (in_byte == CH_LO_X || in_byte == CH_UP_X)
                begin
                    mode_next      = MODE_HEX;
                    hex_value_next = 8'd0;
                    hex_seen_next  = 1'b0;
                    hex_ovf_next   = 1'b0;
                end
                else if (in_byte == CH_LO_N)
                begin
                    results.data_valid = 1'b1;
                    results.data_byte  = CH_NL;
                end
                else if (in_byte == CH_LO_T)
                begin
                    results.data_valid = 1'b1;
                    results.data_byte  = CH_TAB;
                end
                else if (in_byte == CH_LO_R)
                begin
                    results.data_valid = 1'b1;
                    results.data_byte  = CH_CR;
                end
                else
                begin
                    results.data_valid = 1'b1;
                    results.data_byte  = in_byte;
                end
            end
            else if (in_byte == CH_BSLASH)
            begin
                mode_next = MODE_ESCAPE;
            end
            else
            begin
                results.data_valid = 1'b1;
                results.data_byte  = in_byte;
            end

            if (end_of_string)
            begin
                results.status_valid = 1'b1;
                results.status       = (mode_next == MODE_ESCAPE || mode_next == MODE_HEX)
                                       ? ST_SYNTAX : ST_OK;
                clear_all            = 1'b1;
            end
        end

        if (clear_all)
        begin
            mode_next      = MODE_NORMAL;
            hex_value_next = 8'd0;
            hex_seen_next  = 1'b0;
            hex_ovf_next   = 1'b0;
            err_next       = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_NORMAL;
            hex_value_reg <= 8'd0;
            hex_seen_reg  <= 1'b0;
            hex_ovf_reg   <= 1'b0;
            err_reg       <= ST_OK;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            hex_value_reg <= hex_value_next;
            hex_seen_reg  <= hex_seen_next;
            hex_ovf_reg   <= hex_ovf_next;
            err_reg       <= err_next;
        end
    end

endmodule

`default_nettype wire

[design/esd_emit.sv]
// Result register: holds the results of one input word and hands them
// out one word per cycle while ready is high. Depends on esd_pkg, esd_if.
`default_nettype none

module esd_emit
    import esd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire result_set_t results,
    output logic             can_load,
    esd_out_if.source        out_ch
);

    logic       hex_v_reg, data_v_reg, stat_v_reg;
    logic [7:0] hex_b_reg, data_b_reg;
    status_t    stat_reg;
    logic       take;
    logic       one_left;

    assign out_ch.valid = hex_v_reg | data_v_reg | stat_v_reg;
    assign take         = out_ch.valid & out_ch.ready;
    assign one_left     = $countones({hex_v_reg, data_v_reg, stat_v_reg}) == 2'd1;
    assign can_load     = !out_ch.valid || (out_ch.ready && one_left);

    always_comb
    begin
        priority if (hex_v_reg)
        begin
            out_ch.out_byte = hex_b_reg;
            out_ch.is_data  = 1'b1;
            out_ch.status   = ST_OK;
            out_ch.last     = 1'b0;
        end
        else if (data_v_reg)
        begin
            out_ch.out_byte = data_b_reg;
            out_ch.is_data  = 1'b1;
            out_ch.status   = ST_OK;
            out_ch.last     = 1'b0;
        end
        else
        begin
            out_ch.out_byte = 8'd0;
            out_ch.is_data  = 1'b0;
            out_ch.status   = stat_reg;
            out_ch.last     = 1'b1;
        end
    end

    // Flags: load a fresh set, or drop the word just taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_v_reg  <= 1'b0;
            data_v_reg <= 1'b0;
            stat_v_reg <= 1'b0;
        end
        else if (load)
        begin
            hex_v_reg  <= results.hex_valid;
            data_v_reg <= results.data_valid;
            stat_v_reg <= results.status_valid;
        end
        else if (take)
        begin
            priority if (hex_v_reg)
            begin
                hex_v_reg <= 1'b0;
            end
            else if (data_v_reg)
            begin
                data_v_reg <= 1'b0;
            end
            else
            begin
                stat_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hex_b_reg  <= results.hex_byte;
            data_b_reg <= results.data_byte;
            stat_reg   <= results.status;
        end
    end

endmodule

`default_nettype wire

[design/escape_sequence_decoder.sv]
// Escape sequence decoder, top level: decode stage plus result register.
// Depends on esd_pkg, esd_if, esd_decode and esd_emit.
//
// Usage:
//   text    : input channel, one escaped character per word (in_byte) with
//             end_of_string set on the final character of each string.
//   decoded : output channel. Data words carry a decoded byte (is_data = 1);
//             each string closes with one status word (is_data = 0,
//             last = 1, status 0 ok / 1 escape syntax / 2 number format /
//             3 out of range). After an error the rest of the string is
//             dropped and only the status word comes out at its end.
//   Output  : a word's first result shows at the output in the cycle after
//             the word is accepted, from the result register.
//   Rate    : one input word per cycle while each word makes at most one
//             result and decoded.ready is high. A word that makes two or
//             three results (closing hex byte, ending byte, status) holds
//             text.ready low until its last result is leaving, as the result
//             register has a single-word output port.
//   Stall   : while decoded.ready is low the pending results hold; a new
//             word is taken in the same cycle the last pending result leaves.
//   Reset   : rst_n clears the escape/hex state and empties the result
//             register; text.ready is high right after reset.
`default_nettype none

module escape_sequence_decoder
    import esd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    esd_in_if.sink      text,
    esd_out_if.source   decoded
);

    result_set_t results;
    logic        can_load;
    logic        accept;

    // Take a word only when the result register can hold its results
    assign text.ready = can_load;
    assign accept     = text.valid & can_load;

    esd_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (text.in_byte),
        .end_of_string (text.end_of_string),
        .results       (results)
    );

    esd_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .results  (results),
        .can_load (can_load),
        .out_ch   (decoded)
    );

endmodule

`default_nettype wire

[design/esd_checker.sv]
// Port-level checks for the escape sequence decoder, bound to the top level.
// Depends on esd_pkg.
`default_nettype none

module esd_checker
    import esd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_ready,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_byte,
    input  wire logic       is_data,
    input  wire logic [1:0] status,
    input  wire logic       last
);

    // A stalled output word stays and holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
        $stable(is_data) && $stable(status) && $stable(last))
        else $error("output word changed while stalled");

    // A data word never closes a string and carries ok status
    a_data_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_data |-> !last && status == ST_OK)
        else $error("data word with status or last set");

    // A status word closes the string and carries a zero byte
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_data |-> last && out_byte == 8'd0)
        else $error("status word malformed");

    // With nothing pending the block takes input
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no pending output");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (text.ready),
    .out_valid (decoded.valid),
    .out_ready (decoded.ready),
    .out_byte  (decoded.out_byte),
    .is_data   (decoded.is_data),
    .status    (decoded.status),
    .last      (decoded.last)
);

`default_nettype wire
